// File: rtl/core/bba_pkg.sv
// shared types and constants of the block bitmap allocator
`default_nettype none

package bba_pkg;

  localparam int BLK_W   = 12;
  localparam int TOTAL_W = 13;
  localparam int OP_W    = 2;
  localparam int ST_W    = 2;

  localparam logic [TOTAL_W-1:0] TOTAL_RESET = 13'd4096;

  // opcodes
  localparam logic [OP_W-1:0] OP_QUERY = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
  localparam logic [OP_W-1:0] OP_ALLOC = 2'd2;

  // result status codes
  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_BAD     = 2'd1;
  localparam logic [ST_W-1:0] ST_NOSPACE = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]  opcode;
    logic [BLK_W-1:0] block_number;
  } req_t;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [BLK_W-1:0] allocated_block;
  } rsp_t;

endpackage

`default_nettype wire

// File: rtl/core/bba_ram.sv
// generic simple dual-port ram with registered read
`default_nettype none

module bba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// File: rtl/core/bba_find.sv
// lowest set bit of one bitmap row, limited to blocks below the total
`default_nettype none

module bba_find #(
  parameter int ROW_W = 32,
  parameter int IDX_W = 13,
  localparam int BIT_AW = (ROW_W > 1) ? $clog2(ROW_W) : 1
) (
  input  wire logic [ROW_W-1:0]  row_i,
  input  wire logic [IDX_W-1:0]  base_i,
  input  wire logic [IDX_W-1:0]  limit_i,
  output logic                   found_o,
  output logic      [BIT_AW-1:0] idx_o
);

  logic [IDX_W-1:0] room;
  logic [ROW_W-1:0] cand;

  // number of blocks of this row that still lie below the total
  assign room = (limit_i > base_i) ? (limit_i - base_i) : '0;

  always_comb begin
    for (int i = 0; i < ROW_W; i++) begin
      cand[i] = row_i[i] && (room > IDX_W'(i));
    end
  end

  assign found_o = |cand;

  always_comb begin
    idx_o = '0;
    for (int i = ROW_W - 1; i >= 0; i--) begin
      if (cand[i]) begin
        idx_o = BIT_AW'(i);
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/block_bitmap_allocator_core.sv
// Free-block bitmap allocator, first fit. A set bit marks a free block. After
// reset the block sweeps the bitmap ram to all in use, one row per cycle, with
// busy high. A transaction is taken when start is high and busy is low. Query
// and free read one ram row while idle, evaluate it in the evaluate state and
// answer with the result strobe from the result register. Allocate streams ram
// rows through the single first-fit finder, one row per cycle from row 0, until
// a row holds a free block below the total or the scanned rows reach the total;
// the ram read port sets that pace. Rows are BITS_PER_WORD rounded up to a power
// of two wide. The result valid strobe is high for exactly one cycle and result_o
// holds the result until the next one; there is no back pressure, and the next
// transaction may be taken while a result is shown.
// total_blocks may be written only while busy is low.
`default_nettype none

module block_bitmap_allocator_core #(
  parameter int MAX_BLOCKS    = 4096,
  parameter int BITS_PER_WORD = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire bba_pkg::req_t                 req_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [bba_pkg::TOTAL_W-1:0]   cfg_wdata_i,
  output logic                               result_valid_o,
  output bba_pkg::rsp_t                      result_o
);

  localparam int ROW_W  = 1 << $clog2(BITS_PER_WORD);
  localparam int BIT_AW = (ROW_W > 1) ? $clog2(ROW_W) : 1;
  localparam int ROWS   = (MAX_BLOCKS + ROW_W - 1) / ROW_W;
  localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int IDX_A  = BIT_AW + ROW_AW + 1;
  localparam int IDX_B  = $clog2(MAX_BLOCKS + 1);
  localparam int IDX_C  = (IDX_A > IDX_B) ? IDX_A : IDX_B;
  localparam int IDX_W  = (IDX_C > bba_pkg::TOTAL_W) ? IDX_C : bba_pkg::TOTAL_W;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CLEAR = 4'b0010,
    S_EVAL  = 4'b0100,
    S_SCAN  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [bba_pkg::TOTAL_W-1:0] total_q;
  logic [bba_pkg::OP_W-1:0]    op_q, op_d;
  logic [bba_pkg::BLK_W-1:0]   blk_q, blk_d;
  logic [ROW_AW:0]             row_q, row_d;
  logic                        res_valid_q, res_valid_d;
  bba_pkg::rsp_t               res_q, res_d;

  logic              ram_we;
  logic [ROW_AW-1:0] ram_waddr, ram_raddr;
  logic [ROW_W-1:0]  ram_wdata, ram_rdata;

  logic [IDX_W-1:0]  limit, blk_in_ext, blk_ext, base, row_end, alloc_blk;
  logic [BIT_AW-1:0] blk_bit, find_idx;
  logic              find_hit, accept;
  logic [ROW_W-1:0]  one_bit;

  assign accept = start && !busy;
  assign busy   = (state_q != S_IDLE);

  // totals above capacity act as the capacity
  assign limit = (IDX_W'(total_q) > IDX_W'(MAX_BLOCKS)) ? IDX_W'(MAX_BLOCKS) : IDX_W'(total_q);

  assign blk_in_ext = IDX_W'(req_i.block_number);
  assign blk_ext    = IDX_W'(blk_q);
  assign blk_bit    = blk_ext[BIT_AW-1:0];
  assign base       = IDX_W'(row_q) << BIT_AW;
  assign row_end    = IDX_W'(row_q + 1'b1) << BIT_AW;
  assign alloc_blk  = base + IDX_W'(find_idx);
  assign one_bit    = {{(ROW_W - 1){1'b0}}, 1'b1};

  bba_ram #(
    .WIDTH (ROW_W),
    .DEPTH (ROWS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  bba_find #(
    .ROW_W (ROW_W),
    .IDX_W (IDX_W)
  ) u_find (
    .row_i   (ram_rdata),
    .base_i  (base),
    .limit_i (limit),
    .found_o (find_hit),
    .idx_o   (find_idx)
  );

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    blk_d       = blk_q;
    row_d       = row_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    ram_we      = 1'b0;
    ram_waddr   = row_q[ROW_AW-1:0];
    ram_wdata   = '0;
    ram_raddr   = ROW_AW'(row_q + 1'b1);

    case (state_q)
      S_CLEAR: begin
        ram_we = 1'b1;
        row_d  = row_q + 1'b1;
        if (row_q == (ROW_AW + 1)'(ROWS - 1)) begin
          row_d   = '0;
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (req_i.opcode == bba_pkg::OP_ALLOC) begin
          ram_raddr = '0;
        end else begin
          ram_raddr = blk_in_ext[BIT_AW +: ROW_AW];
        end
        if (accept) begin
          op_d  = req_i.opcode;
          blk_d = req_i.block_number;
          row_d = '0;
          if (req_i.opcode == bba_pkg::OP_ALLOC) begin
            state_d = S_SCAN;
          end else begin
            state_d = S_EVAL;
          end
        end
      end

      S_EVAL: begin
        res_valid_d                 = 1'b1;
        res_d.allocated_block       = '0;
        res_d.status                = bba_pkg::ST_BAD;
        ram_waddr                   = blk_ext[BIT_AW +: ROW_AW];
        ram_wdata                   = ram_rdata | (one_bit << blk_bit);
        state_d                     = S_IDLE;
        case (op_q)
          bba_pkg::OP_QUERY: begin
            if (blk_ext < limit && ram_rdata[blk_bit]) begin
              res_d.status = bba_pkg::ST_OK;
            end
          end
          bba_pkg::OP_FREE: begin
            if (blk_ext < IDX_W'(MAX_BLOCKS)) begin
              res_d.status = bba_pkg::ST_OK;
              // block zero is the null block and is never freed
              ram_we       = (blk_q != '0);
            end
          end
          default: begin
            res_d.status = bba_pkg::ST_BAD;
          end
        endcase
      end

      S_SCAN: begin
        row_d = row_q + 1'b1;
        if (find_hit) begin
          ram_we                = 1'b1;
          ram_wdata             = ram_rdata & ~(one_bit << find_idx);
          res_valid_d           = 1'b1;
          res_d.status          = bba_pkg::ST_OK;
          res_d.allocated_block = alloc_blk[bba_pkg::BLK_W-1:0];
          state_d               = S_IDLE;
        end else if (row_end >= limit) begin
          res_valid_d           = 1'b1;
          res_d.status          = bba_pkg::ST_NOSPACE;
          res_d.allocated_block = '0;
          state_d               = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      row_q       <= '0;
      res_valid_q <= 1'b0;
      total_q     <= bba_pkg::TOTAL_RESET;
    end else begin
      state_q     <= state_d;
      row_q       <= row_d;
      res_valid_q <= res_valid_d;
      if (cfg_we_i) begin
        total_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    blk_q <= blk_d;
    res_q <= res_d;
  end

  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

endmodule

`default_nettype wire

// File: rtl/core/bba_checker.sv
// port-level checks for the block bitmap allocator, bound to the top level
`default_nettype none

module bba_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        start,
  input wire logic                        busy,
  input wire bba_pkg::req_t               req_i,
  input wire logic                        cfg_we_i,
  input wire logic [bba_pkg::TOTAL_W-1:0] cfg_wdata_i,
  input wire logic                        result_valid_o,
  input wire bba_pkg::rsp_t               result_o
);

  logic unused_ok;
  assign unused_ok = ^{req_i, cfg_we_i, cfg_wdata_i};

  // the block is busy in the cycle after it accepts a transaction
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("block not busy after a transaction was taken");

  // a result only follows a cycle of work
  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy))
    else $error("result strobe without preceding work");

  // every transaction does busy work before its result, so strobes never touch
  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("back-to-back result strobes");

  // a block number is only reported by a successful allocate
  a_block_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (result_o.allocated_block != '0)
      |-> (result_o.status == bba_pkg::ST_OK))
    else $error("allocated block reported with a failing status");

endmodule

bind block_bitmap_allocator_core bba_checker u_bba_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .req_i          (req_i),
  .cfg_we_i       (cfg_we_i),
  .cfg_wdata_i    (cfg_wdata_i),
  .result_valid_o (result_valid_o),
  .result_o       (result_o)
);

`default_nettype wire

// File: tb/block_bitmap_allocator_core_tb.sv
// testbench for the first-fit block bitmap allocator core
`timescale 1ns / 100ps

class alloc_scoreboard;
  localparam int MAX_BLOCKS = 4096;

  bit [MAX_BLOCKS-1:0]           free_map;
  logic [bba_pkg::TOTAL_W-1:0]   total_blocks;
  bba_pkg::rsp_t                 pending_rsp[$];
  int                            errors;

  function new();
    free_map     = '0;
    total_blocks = bba_pkg::TOTAL_RESET;
    errors       = 0;
  endfunction

  function void write_total(logic [bba_pkg::TOTAL_W-1:0] value);
    total_blocks = value;
  endfunction

  // work out the response of one accepted request and update the bitmap
  function void note_request(bba_pkg::req_t req);
    bba_pkg::rsp_t rsp;
    int unsigned   lim;
    int unsigned   b;
    rsp.status          = bba_pkg::ST_BAD;
    rsp.allocated_block = '0;
    lim = (int'(total_blocks) > MAX_BLOCKS) ? MAX_BLOCKS : int'(total_blocks);
    case (req.opcode)
      bba_pkg::OP_QUERY: begin
        if (req.block_number < lim && free_map[req.block_number]) rsp.status = bba_pkg::ST_OK;
      end
      bba_pkg::OP_FREE: begin
        // block zero is the null block and never becomes free
        if (req.block_number != '0) free_map[req.block_number] = 1'b1;
        rsp.status = bba_pkg::ST_OK;
      end
      bba_pkg::OP_ALLOC: begin
        rsp.status = bba_pkg::ST_NOSPACE;
        for (b = 0; b < lim; b++) begin
          if (free_map[b]) begin
            free_map[b]         = 1'b0;
            rsp.status          = bba_pkg::ST_OK;
            rsp.allocated_block = b[bba_pkg::BLK_W-1:0];
            break;
          end
        end
      end
      default: ;
    endcase
    pending_rsp.push_back(rsp);
  endfunction

  function void check_result(bba_pkg::rsp_t got);
    bba_pkg::rsp_t want;
    if (pending_rsp.size() == 0) begin
      $display("%0t: unexpected result status=%0d block=%0d", $time,
               got.status, got.allocated_block);
      errors++;
      return;
    end
    want = pending_rsp.pop_front();
    if (got.status !== want.status) begin
      $display("%0t: status mismatch expected=%0d actual=%0d", $time,
               want.status, got.status);
      errors++;
    end
    if (got.allocated_block !== want.allocated_block) begin
      $display("%0t: allocated_block mismatch expected=%0d actual=%0d", $time,
               want.allocated_block, got.allocated_block);
      errors++;
    end
  endfunction

  function int pending();
    return pending_rsp.size();
  endfunction
endclass

module block_bitmap_allocator_core_tb;
  typedef logic [bba_pkg::OP_W-1:0]    op_t;
  typedef logic [bba_pkg::BLK_W-1:0]   blk_t;
  typedef logic [bba_pkg::TOTAL_W-1:0] total_t;

  localparam op_t OP_UNUSED       = 2'd3;
  localparam int  MAX_BLOCKS      = 4096;
  localparam int  ITEMS_PER_PHASE = 170;

  logic          clk = 1'b0;
  logic          rst_n;
  logic          start;
  logic          busy;
  bba_pkg::req_t req;
  logic          cfg_we;
  total_t        cfg_wdata;
  logic          result_valid;
  bba_pkg::rsp_t result;

  alloc_scoreboard sb = new();
  bit              quiet;
  int unsigned     cur_limit;

  block_bitmap_allocator_core dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .start          (start),
    .busy           (busy),
    .req_i          (req),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .result_valid_o (result_valid),
    .result_o       (result)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // sample every transaction on the edge that accepts it
  always @(posedge clk) begin
    if (rst_n) begin
      if (result_valid) sb.check_result(result);
      if (start && !busy) sb.note_request(req);
      if (cfg_we) sb.write_total(cfg_wdata);
    end
  end

  function automatic int pick_gap();
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return int'($urandom_range(1, 3));
    if (r < 98) return int'($urandom_range(4, 15));
    return int'($urandom_range(30, 200));
  endfunction

  task automatic send(op_t op, blk_t blk);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    req   <= '{opcode: op, block_number: blk};
    do @(posedge clk); while (busy);
  endtask

  // wait for every response, then write the disk size while the block is idle
  task automatic set_total(total_t value);
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    while (busy) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_limit = (int'(value) > MAX_BLOCKS) ? MAX_BLOCKS : int'(value);
  endtask

  function automatic blk_t pick_block();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50 && cur_limit > 0) return blk_t'($urandom_range(0, cur_limit - 1));
    if (r < 70) return blk_t'($urandom_range(0, 63));
    return blk_t'($urandom_range(0, MAX_BLOCKS - 1));
  endfunction

  task automatic random_phase(int count);
    int          i;
    int unsigned r;
    for (i = 0; i < count; i++) begin
      if (i % 60 == 0) quiet = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 40)      send(bba_pkg::OP_FREE, pick_block());
      else if (r < 75) send(bba_pkg::OP_ALLOC, blk_t'($urandom_range(0, MAX_BLOCKS - 1)));
      else if (r < 95) send(bba_pkg::OP_QUERY, pick_block());
      else             send(OP_UNUSED, blk_t'($urandom_range(0, MAX_BLOCKS - 1)));
    end
  endtask

  initial begin
    total_t totals[7];
    int     p;
    rst_n     <= 1'b0;
    start     <= 1'b0;
    req       <= '0;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    quiet     = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    set_total(bba_pkg::TOTAL_RESET);

    // directed: empty map, null block, edges of the map, unused opcode
    send(bba_pkg::OP_QUERY, 12'd0);
    send(bba_pkg::OP_QUERY, 12'hFFF);
    send(bba_pkg::OP_ALLOC, 12'd0);
    send(bba_pkg::OP_FREE, 12'd0);
    send(bba_pkg::OP_ALLOC, 12'hFFF);
    send(bba_pkg::OP_FREE, 12'hFFF);
    send(bba_pkg::OP_FREE, 12'd1);
    send(bba_pkg::OP_FREE, 12'd31);
    send(bba_pkg::OP_FREE, 12'd32);
    send(bba_pkg::OP_QUERY, 12'hFFF);
    send(bba_pkg::OP_QUERY, 12'd1);
    send(bba_pkg::OP_ALLOC, 12'd0);
    send(bba_pkg::OP_ALLOC, 12'd0);
    send(bba_pkg::OP_ALLOC, 12'd0);
    send(bba_pkg::OP_ALLOC, 12'd0);
    send(bba_pkg::OP_ALLOC, 12'd0);
    send(OP_UNUSED, 12'hFFF);
    send(bba_pkg::OP_FREE, 12'hFFF);
    send(bba_pkg::OP_FREE, 12'd5);
    // freed block above a small total stays hidden
    set_total(13'd100);
    send(bba_pkg::OP_QUERY, 12'hFFF);
    send(bba_pkg::OP_ALLOC, 12'd0);
    send(bba_pkg::OP_ALLOC, 12'd0);
    set_total(13'd0);
    send(bba_pkg::OP_QUERY, 12'd0);
    send(bba_pkg::OP_ALLOC, 12'd0);
    // total above capacity acts as the full disk
    set_total(13'h1FFF);
    send(bba_pkg::OP_QUERY, 12'hFFF);
    send(bba_pkg::OP_ALLOC, 12'd0);

    totals[0] = bba_pkg::TOTAL_RESET;
    totals[1] = 13'd1;
    totals[2] = 13'd37;
    totals[3] = total_t'($urandom_range(1, MAX_BLOCKS));
    totals[4] = 13'h1FFF;
    totals[5] = total_t'($urandom_range(0, 13'h1FFF));
    totals[6] = bba_pkg::TOTAL_RESET;
    for (p = 0; p < 7; p++) begin
      set_total(totals[p]);
      random_phase(ITEMS_PER_PHASE);
    end

    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (140) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("timeout with %0d responses outstanding", sb.pending());
    $display("*** FAILED ***");
    $finish;
  end
endmodule
